[rtl/core/powerpc_exception_dispatch_macros.svh]
// Assertion macros shared by the exception dispatch RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef POWERPC_EXCEPTION_DISPATCH_MACROS_SVH
`define POWERPC_EXCEPTION_DISPATCH_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define PED_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("exception dispatch assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define PED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("exception dispatch assertion failed");

`endif

[rtl/core/ped_pkg.sv]
// Package for the exception dispatch block: exception kinds, masks, vectors,
// stage and result types, and the delivery function. No dependencies.
package ped_pkg;

    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 208;
    localparam int OUT_USER_W = 2;
    localparam int NKINDS     = 13;

    localparam logic [63:0] SAVE_MASK   = 64'hFFFF_FFFF_87C0_FFFF;
    localparam logic [63:0] KEEP_MASK   = 64'hFFFF_FFFF_FFFF_10C8;
    localparam logic [63:0] FORCE_BITS  = 64'h9000_0000_0000_0000;
    localparam logic [63:0] WAKE_MASK   = 64'h0000_0000_0038_0000;
    localparam logic [63:0] ISTOR_CAUSE = 64'h0000_0000_4000_0000;

    // MSR bit positions, LSB numbering
    localparam int MSR_SF = 63;
    localparam int MSR_HV = 60;
    localparam int MSR_EE = 15;
    localparam int MSR_ME = 12;

    // Exception kinds; value is the bit position in the raise mask
    typedef enum logic [3:0] {
        K_RESET  = 4'd0,
        K_MCHECK = 4'd1,
        K_DSTOR  = 4'd2,
        K_DSEG   = 4'd3,
        K_ISTOR  = 4'd4,
        K_ISEG   = 4'd5,
        K_EXT    = 4'd6,
        K_PROG   = 4'd7,
        K_FPU    = 4'd8,
        K_DEC    = 4'd9,
        K_SYSC   = 4'd10,
        K_VXU    = 4'd11,
        K_HDEC   = 4'd12
    } t_kind;

    typedef struct packed {
        logic  sync_v;
        t_kind sync_k;
        logic  async_v;
        t_kind async_k;
        logic  stop;
    } t_decision;

    typedef struct packed {
        logic [63:0] cia;
        logic [63:0] nia;
        logic [63:0] msr;
        logic [5:0]  pbit;
        logic [2:0]  wake;
        t_decision   dec;
    } t_stage;

    typedef struct packed {
        logic        delivered;
        logic        checkstop;
        logic [11:0] vector;
        logic        hyper;
        logic [63:0] saved_pc;
        logic [63:0] saved_status;
        logic [63:0] new_state;
    } t_result;

    function automatic logic [11:0] vec_of(t_kind k);
        logic [11:0] v;
        unique case (k)
            K_RESET, K_MCHECK: v = 12'h100;
            K_DSTOR:           v = 12'h300;
            K_DSEG:            v = 12'h380;
            K_ISTOR:           v = 12'h400;
            K_ISEG:            v = 12'h480;
            K_EXT:             v = 12'h500;
            K_PROG:            v = 12'h700;
            K_FPU:             v = 12'h800;
            K_DEC:             v = 12'h900;
            K_SYSC:            v = 12'hC00;
            K_VXU:             v = 12'hF20;
            K_HDEC:            v = 12'h980;
            default:           v = 12'h000;
        endcase
        return v;
    endfunction

    // One delivery: saved PC/status and the handler MSR
    function automatic t_result deliver(t_kind k, logic [63:0] cia, logic [63:0] nia,
                                        logic [63:0] msr, logic [63:0] wake,
                                        logic [5:0] pbit);
        logic        use_next;
        logic [63:0] pc;
        logic [63:0] st;
        t_result     r;
        use_next = (k == K_RESET) || (k == K_MCHECK) || (k == K_EXT) || (k == K_DEC) ||
                   (k == K_HDEC) || (k == K_SYSC);
        pc = use_next ? nia : cia;
        if (!msr[MSR_SF]) begin
            pc[63:32] = 32'd0;
        end
        st = msr & SAVE_MASK;
        if (k == K_ISTOR) begin
            st = st | ISTOR_CAUSE;
        end
        if (k == K_PROG) begin
            st = st | (64'd1 << (6'd63 - pbit));
        end
        if (k == K_RESET) begin
            st = st | (wake & WAKE_MASK);
        end
        r.delivered    = 1'b1;
        r.checkstop    = 1'b0;
        r.vector       = vec_of(k);
        r.hyper        = (k == K_HDEC);
        r.saved_pc     = pc;
        r.saved_status = st;
        r.new_state    = (msr & KEEP_MASK) | FORCE_BITS;
        return r;
    endfunction

endpackage

[rtl/core/ped_sched.sv]
// Pending-set register, config register and per-item priority decision.
// Depends on ped_pkg and the assertion macro header.
`include "powerpc_exception_dispatch_macros.svh"

module ped_sched (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ped_pkg::IN_DATA_W-1:0] i_in_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data,
    input  logic                      i_consume,
    output logic                      o_stage_valid,
    output ped_pkg::t_stage           o_stage
);
    import ped_pkg::*;

    logic [NKINDS-1:0] r_pending, n_pending;
    logic              r_hyp_dec_enable;
    logic              r_s_valid;
    t_stage            r_stage, n_stage;

    logic [NKINDS-1:0] raise, pend, clr;
    logic [63:0]       msr;
    logic              ee2, hv2, any_result, accept;
    t_decision         dec;

    assign raise = i_in_data[12:0];
    assign msr   = i_in_data[204:141];

    always_comb begin
        pend = r_pending | raise;
        clr  = '0;
        dec  = '{sync_v: 1'b1, sync_k: K_DSTOR, async_v: 1'b1, async_k: K_RESET,
                 stop: 1'b0};
        if      (pend[K_DSTOR]) dec.sync_k = K_DSTOR;
        else if (pend[K_DSEG])  dec.sync_k = K_DSEG;
        else if (pend[K_FPU])   dec.sync_k = K_FPU;
        else if (pend[K_VXU])   dec.sync_k = K_VXU;
        else if (pend[K_PROG])  dec.sync_k = K_PROG;
        else if (pend[K_SYSC])  dec.sync_k = K_SYSC;
        else if (pend[K_ISTOR]) dec.sync_k = K_ISTOR;
        else if (pend[K_ISEG])  dec.sync_k = K_ISEG;
        else                    dec.sync_v = 1'b0;
        if (dec.sync_v) begin
            clr[dec.sync_k] = 1'b1;
        end
        // a sync delivery leaves EE clear and HV set; ME passes through
        ee2 = !dec.sync_v && msr[MSR_EE];
        hv2 = dec.sync_v || msr[MSR_HV];
        if (pend[K_RESET]) begin
            dec.async_k = K_RESET;
        end else if (pend[K_MCHECK]) begin
            dec.async_k = K_MCHECK;
            if (!msr[MSR_ME]) begin
                dec.async_v = 1'b0;
                dec.stop    = 1'b1;
            end
        end else if (ee2 && pend[K_EXT]) begin
            dec.async_k = K_EXT;
        end else if (ee2 && pend[K_DEC]) begin
            dec.async_k = K_DEC;
        end else if (pend[K_HDEC]) begin
            dec.async_k = K_HDEC;
            if (!r_hyp_dec_enable) begin
                dec.async_v   = 1'b0;
                clr[K_HDEC]   = 1'b1;
            end else if (hv2 && !ee2) begin
                dec.async_v = 1'b0;
            end
        end else begin
            dec.async_v = 1'b0;
        end
        if (dec.async_v) begin
            clr[dec.async_k] = 1'b1;
        end
        n_pending  = pend & ~clr;
        any_result = dec.sync_v || dec.async_v || dec.stop;
        n_stage.cia  = i_in_data[76:13];
        n_stage.nia  = i_in_data[140:77];
        n_stage.msr  = msr;
        n_stage.pbit = i_in_data[210:205];
        n_stage.wake = i_in_data[213:211];
        n_stage.dec  = dec;
    end

    assign o_in_ready  = !r_s_valid || i_consume;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending        <= '0;
            r_hyp_dec_enable <= 1'b0;
            r_s_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hyp_dec_enable <= i_cfg_data;
            end
            if (accept) begin
                r_pending <= n_pending;
                r_s_valid <= any_result;
            end else if (i_consume) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept && any_result) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage_valid = r_s_valid;
    assign o_stage       = r_stage;

    `PED_ASSERT_IMPL(a_stage_has_work, i_clk, i_rst_n, r_s_valid,
                     r_stage.dec.sync_v || r_stage.dec.async_v || r_stage.dec.stop)
    `PED_ASSERT_IMPL(a_stop_excl, i_clk, i_rst_n, r_s_valid,
                     !(r_stage.dec.stop && r_stage.dec.async_v))
    `PED_ASSERT_NEXT(a_stop_keeps_mcheck, i_clk, i_rst_n, accept && dec.stop,
                     r_pending[K_MCHECK])
endmodule

[rtl/core/ped_emit.sv]
// Builds up to two results per staged item and drives the output register.
// Depends on ped_pkg and the assertion macro header.
`include "powerpc_exception_dispatch_macros.svh"

module ped_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_stage_valid,
    input  ped_pkg::t_stage               i_stage,
    output logic                          o_consume,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ped_pkg::OUT_DATA_W-1:0] o_out_data,   // vector, to_hyper_pair,
                                                        // saved_pc, saved_status,
                                                        // new_state, zero pad
    output logic [ped_pkg::OUT_USER_W-1:0] o_out_user,   // delivered, checkstop
    output logic                          o_out_last
);
    import ped_pkg::*;

    logic    r_idx;
    logic    r_m_valid;
    logic    r_m_last;
    t_result r_res;

    t_result     res_sync, res_async, res_sel;
    logic [63:0] a_msr, a_nia, a_wake;
    logic        async_any, is_last, o_free, load;

    always_comb begin
        res_sync = deliver(i_stage.dec.sync_k, i_stage.cia, i_stage.nia, i_stage.msr,
                           {42'd0, i_stage.wake, 19'd0}, i_stage.pbit);
        // chained delivery sees the first handler's MSR, vector and save status
        if (i_stage.dec.sync_v) begin
            a_msr  = res_sync.new_state;
            a_nia  = {52'd0, res_sync.vector};
            a_wake = res_sync.saved_status;
        end else begin
            a_msr  = i_stage.msr;
            a_nia  = i_stage.nia;
            a_wake = {42'd0, i_stage.wake, 19'd0};
        end
        res_async = deliver(i_stage.dec.async_k, i_stage.cia, a_nia, a_msr, a_wake,
                            i_stage.pbit);
        if (i_stage.dec.stop) begin
            res_async           = '0;
            res_async.checkstop = 1'b1;
        end
        async_any = i_stage.dec.async_v || i_stage.dec.stop;
        res_sel   = (!r_idx && i_stage.dec.sync_v) ? res_sync : res_async;
        is_last   = r_idx || !(i_stage.dec.sync_v && async_any);
    end

    assign o_free    = !r_m_valid || i_out_ready;
    assign load      = i_stage_valid && o_free;
    assign o_consume = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= !is_last;
            end
            if (o_free) begin
                r_m_valid <= i_stage_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res    <= res_sel;
            r_m_last <= is_last;
        end
    end

    assign o_out_valid = r_m_valid;
    assign o_out_last  = r_m_last;
    assign o_out_user  = {r_res.checkstop, r_res.delivered};
    assign o_out_data  = {3'd0, r_res.new_state, r_res.saved_status, r_res.saved_pc,
                          r_res.hyper, r_res.vector};

    `PED_ASSERT_IMPL(a_second_needs_two, i_clk, i_rst_n, r_idx,
                     i_stage_valid && i_stage.dec.sync_v && async_any)
    `PED_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, r_m_valid,
                     !(r_res.delivered && r_res.checkstop))
    `PED_ASSERT_NEXT(a_first_of_two, i_clk, i_rst_n, load && !is_last,
                     r_idx && r_m_valid && !r_m_last)
endmodule

[rtl/core/powerpc_exception_dispatch.sv]
// Exception dispatch at an instruction boundary: the stage register and the output register lie
// between an input transfer and its first result. While the output is not stalled, one result per cycle
// goes out, and one input item per cycle is taken when it yields at most one result; a chained pair holds the stage.
// Reset (i_rst_n low, synchronous) clears the pending set, the enable bit
// and all valid flags.
// Depends on ped_pkg, ped_sched and ped_emit.
module powerpc_exception_dispatch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ped_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // raise_mask[12:0],
                                                           // current_addr[76:13],
                                                           // next_addr[140:77],
                                                           // machine_state[204:141],
                                                           // program_cause_bit[210:205],
                                                           // wake_cause[213:211], pad
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ped_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // vector[11:0],
                                                           // to_hyper_pair[12],
                                                           // saved_pc[76:13],
                                                           // saved_status[140:77],
                                                           // new_state[204:141], pad
    output logic [ped_pkg::OUT_USER_W-1:0] m_axis_tuser,   // delivered[0], checkstop[1]
    output logic                           m_axis_tlast,   // last result of the item
    // hyp_dec_enable write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data
);
    import ped_pkg::*;

    // Stage 1 (ped_sched): pending set is updated and priority resolved at the
    // input transfer, so the next item sees the new pending set right away.
    // Items that produce nothing never occupy the stage register.
    // Stage 2 (ped_emit): both deliveries are formed from the stage register;
    // the output register takes one per cycle when the output is not stalled and frees the stage on the last.
    logic   stage_valid;
    logic   consume;
    t_stage stage;

    ped_sched u_sched (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_consume     (consume),
        .o_stage_valid (stage_valid),
        .o_stage       (stage)
    );

    ped_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage_valid (stage_valid),
        .i_stage       (stage),
        .o_consume     (consume),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_user    (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );
endmodule
